FILE: rtl/core/lrukv_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// LRU key/value cache package
// Shared widths, controller command type and slot search helper.
// ----------------------------------------------------------------------------
package lrukv_pkg;

  localparam int MAX_ENTRIES = 16;
  localparam int IDX_W       = $clog2(MAX_ENTRIES);
  localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
  localparam int KEY_W       = 16;
  localparam int VAL_W       = 32;
  localparam int CAP_W       = 5;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(MAX_ENTRIES);
  localparam logic             CMD_GET   = 1'b0;
  localparam logic             CMD_SET   = 1'b1;

  typedef logic [IDX_W-1:0]       idx_t;
  typedef logic [CNT_W-1:0]       cnt_t;
  typedef logic [MAX_ENTRIES-1:0] vec_t;

  typedef struct packed {
    logic load;
    logic match;
    logic commit;
  } lrukv_cmd_t;

  // Lowest set bit position; zero when no bit is set.
  function automatic idx_t first_set(vec_t v);
    idx_t r;
    r = '0;
    for (int i = MAX_ENTRIES - 1; i >= 0; i--) begin
      if (v[i]) begin
        r = IDX_W'(i);
      end
    end
    return r;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/core/lrukv_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// LRU key/value cache controller
// Sequences each transaction through match and commit steps.
// ----------------------------------------------------------------------------
module lrukv_ctrl (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 start,
  output logic                busy,
  output logic                out_valid,
  output lrukv_pkg::lrukv_cmd_t cmd
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_MATCH  = 2'd1;
  localparam logic [1:0] ST_COMMIT = 2'd2;

  logic [1:0] state_r;
  logic [1:0] state_nxt;
  logic       accept;

  assign busy   = (state_r == ST_MATCH);
  assign accept = start && !busy;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE, ST_COMMIT: begin
        state_nxt = accept ? ST_MATCH : ST_IDLE;
      end
      ST_MATCH: begin
        state_nxt = ST_COMMIT;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign cmd.load   = accept;
  assign cmd.match  = (state_r == ST_MATCH);
  assign cmd.commit = (state_r == ST_COMMIT);
  assign out_valid  = cmd.commit;

endmodule
`default_nettype wire

FILE: rtl/core/lrukv_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// LRU key/value cache datapath
// Entry store, parallel key compare, recency ranks and result formatting.
// ----------------------------------------------------------------------------
module lrukv_dp (
  input  wire                                  clk,
  input  wire                                  rst_n,
  input  lrukv_pkg::lrukv_cmd_t                cmd,
  input  wire                                  in_command,
  input  wire  [lrukv_pkg::KEY_W-1:0]          in_key,
  input  wire  signed [lrukv_pkg::VAL_W-1:0]   in_value,
  input  wire                                  cfg_we,
  input  wire  [lrukv_pkg::CAP_W-1:0]          cfg_data,
  output logic                                 out_hit,
  output logic signed [lrukv_pkg::VAL_W-1:0]   out_read_value
);

  localparam int N = lrukv_pkg::MAX_ENTRIES;

  logic [lrukv_pkg::VAL_W-1:0] val_mem [N];
  logic [lrukv_pkg::KEY_W-1:0] key_r   [N];
  lrukv_pkg::idx_t             rank_r  [N];
  lrukv_pkg::vec_t             valid_r;
  lrukv_pkg::cnt_t             occ_r;
  logic [lrukv_pkg::CAP_W-1:0] cap_r;

  logic                        cmd_r;
  logic [lrukv_pkg::KEY_W-1:0] in_key_r;
  logic [lrukv_pkg::VAL_W-1:0] in_val_r;

  logic                        hit_r;
  logic                        upd_r;
  logic                        grow_r;
  lrukv_pkg::idx_t             tgt_r;
  lrukv_pkg::cnt_t             thr_r;
  logic [lrukv_pkg::VAL_W-1:0] rdata_r;

  lrukv_pkg::vec_t match_vec;
  lrukv_pkg::vec_t free_vec;
  lrukv_pkg::vec_t oldest_vec;
  lrukv_pkg::idx_t hit_slot;
  lrukv_pkg::idx_t free_slot;
  lrukv_pkg::idx_t old_slot;
  lrukv_pkg::idx_t occ_last;
  lrukv_pkg::cnt_t eff_cap;
  logic            any_hit;
  logic            full;
  lrukv_pkg::idx_t tgt_nxt;
  lrukv_pkg::cnt_t thr_nxt;
  logic            grow_nxt;

  assign occ_last = lrukv_pkg::IDX_W'(occ_r - lrukv_pkg::cnt_t'(1));

  always_comb begin
    for (int i = 0; i < N; i++) begin
      match_vec[i]  = valid_r[i] && (key_r[i] == in_key_r);
      free_vec[i]   = !valid_r[i];
      oldest_vec[i] = valid_r[i] && (rank_r[i] == occ_last);
    end
  end

  assign hit_slot  = lrukv_pkg::first_set(match_vec);
  assign free_slot = lrukv_pkg::first_set(free_vec);
  assign old_slot  = lrukv_pkg::first_set(oldest_vec);
  assign any_hit   = |match_vec;

  always_comb begin
    if (cap_r == '0) begin
      eff_cap = lrukv_pkg::cnt_t'(1);
    end else if (cap_r > lrukv_pkg::CAP_W'(N)) begin
      eff_cap = lrukv_pkg::cnt_t'(N);
    end else begin
      eff_cap = lrukv_pkg::cnt_t'(cap_r);
    end
  end

  assign full = (occ_r >= eff_cap);

  always_comb begin
    priority if (any_hit) begin
      tgt_nxt  = hit_slot;
      thr_nxt  = {1'b0, rank_r[hit_slot]};
      grow_nxt = 1'b0;
    end else if (!full) begin
      tgt_nxt  = free_slot;
      thr_nxt  = lrukv_pkg::cnt_t'(N);
      grow_nxt = 1'b1;
    end else begin
      tgt_nxt  = old_slot;
      thr_nxt  = {1'b0, rank_r[old_slot]};
      grow_nxt = 1'b0;
    end
  end

  // Latch request, resolve the slot, then apply the update.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_r    <= in_command;
      in_key_r <= in_key;
      in_val_r <= in_value;
    end
    if (cmd.match) begin
      hit_r   <= any_hit;
      upd_r   <= any_hit || (cmd_r == lrukv_pkg::CMD_SET);
      grow_r  <= grow_nxt;
      tgt_r   <= tgt_nxt;
      thr_r   <= thr_nxt;
      rdata_r <= val_mem[hit_slot];
    end
    if (cmd.commit && (cmd_r == lrukv_pkg::CMD_SET)) begin
      val_mem[tgt_r] <= in_val_r;
      key_r[tgt_r]   <= in_key_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      occ_r   <= '0;
      cap_r   <= lrukv_pkg::CAP_RESET;
      for (int i = 0; i < N; i++) begin
        rank_r[i] <= '0;
      end
    end else begin
      if (cfg_we) begin
        cap_r <= cfg_data;
      end
      if (cmd.commit && upd_r) begin
        for (int i = 0; i < N; i++) begin
          if (lrukv_pkg::IDX_W'(i) == tgt_r) begin
            rank_r[i] <= '0;
          end else if (valid_r[i] && ({1'b0, rank_r[i]} < thr_r)) begin
            rank_r[i] <= rank_r[i] + lrukv_pkg::idx_t'(1);
          end
        end
        if (cmd_r == lrukv_pkg::CMD_SET) begin
          valid_r[tgt_r] <= 1'b1;
          if (!hit_r && grow_r) begin
            occ_r <= occ_r + lrukv_pkg::cnt_t'(1);
          end
        end
      end
    end
  end

  always_comb begin
    out_hit = hit_r;
    priority if (cmd_r == lrukv_pkg::CMD_SET) begin
      out_read_value = '0;
    end else if (hit_r) begin
      out_read_value = rdata_r;
    end else begin
      out_read_value = '1;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/lru_key_value_cache.sv
`default_nettype none
// ----------------------------------------------------------------------------
// LRU key/value cache
// Fully associative 16-entry key/value store with least-recently-used
// replacement.
//
// Request channel: an in_command/in_key/in_value transaction is taken at a
// clock edge with start high and busy low. Get returns the stored value on a
// hit and -1 on a miss; set updates or inserts and returns 0. out_hit tells
// whether the key was present before the request.
// Result channel: out_valid strobes for one cycle with out_hit and
// out_read_value; the receiver cannot stall and must take it then.
// Sequence: after the accepting edge the controller holds the match state,
// with busy high, then the commit state, in which out_valid is high.
// Overlap: a new request can be taken in the result cycle, but not while
// busy is high in the match state.
// Configuration: cfg_data sets the capacity (0 acts as 1, above 16 as 16).
// The user writes it only while idle; unchecked. cfg_ready is always high.
// Reset (rst_n low, synchronous): cache empty, capacity 16, no
// transaction in flight.
// ----------------------------------------------------------------------------
module lru_key_value_cache (
  input  wire                                  clk,
  input  wire                                  rst_n,
  input  wire                                  start,
  output logic                                 busy,
  input  wire                                  in_command,
  input  wire  [lrukv_pkg::KEY_W-1:0]          in_key,
  input  wire  signed [lrukv_pkg::VAL_W-1:0]   in_value,
  output logic                                 out_valid,
  output logic                                 out_hit,
  output logic signed [lrukv_pkg::VAL_W-1:0]   out_read_value,
  input  wire                                  cfg_valid,
  output logic                                 cfg_ready,
  input  wire  [lrukv_pkg::CAP_W-1:0]          cfg_data
);

  lrukv_pkg::lrukv_cmd_t cmd;

  assign cfg_ready = 1'b1;

  lrukv_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  lrukv_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .in_command     (in_command),
    .in_key         (in_key),
    .in_value       (in_value),
    .cfg_we         (cfg_valid && cfg_ready),
    .cfg_data       (cfg_data),
    .out_hit        (out_hit),
    .out_read_value (out_read_value)
  );

endmodule
`default_nettype wire

FILE: rtl/core/lrukv_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// LRU key/value cache port checker
// Port-level timing and result-encoding checks, bound to the top level.
// ----------------------------------------------------------------------------
module lrukv_checker (
  input wire                                 clk,
  input wire                                 rst_n,
  input wire                                 start,
  input wire                                 busy,
  input wire                                 out_valid,
  input wire                                 out_hit,
  input wire signed [lrukv_pkg::VAL_W-1:0]   out_read_value
);

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (busy && !out_valid))
    else $error("accepted transaction did not raise busy");

  a_busy_result: assert property (@(posedge clk) disable iff (!rst_n)
    busy |=> (out_valid && !busy))
    else $error("busy cycle not followed by result strobe");

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  a_miss_value: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_hit) |->
      (out_read_value == '0 || out_read_value == '1))
    else $error("miss result carries a stored value");

endmodule

bind lru_key_value_cache lrukv_checker u_lrukv_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .start          (start),
  .busy           (busy),
  .out_valid      (out_valid),
  .out_hit        (out_hit),
  .out_read_value (out_read_value)
);
`default_nettype wire

FILE: sim/lru_key_value_cache_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRU key/value cache checker
// Watches the request, result and capacity channels, keeps its own copy of the
// entries and their recency order, and compares each result with the oldest
// predicted one.
// ----------------------------------------------------------------------------
module lru_key_value_cache_checker (
  input  wire                                  clk,
  input  wire                                  rst_n,
  input  wire                                  start,
  input  wire                                  busy,
  input  wire                                  in_command,
  input  wire  [lrukv_pkg::KEY_W-1:0]          in_key,
  input  wire  signed [lrukv_pkg::VAL_W-1:0]   in_value,
  input  wire                                  out_valid,
  input  wire                                  out_hit,
  input  wire  signed [lrukv_pkg::VAL_W-1:0]   out_read_value,
  input  wire                                  cfg_valid,
  input  wire                                  cfg_ready,
  input  wire  [lrukv_pkg::CAP_W-1:0]          cfg_data,
  output int                                   error_count,
  output int                                   pending_count
);

  localparam int KEY_W       = lrukv_pkg::KEY_W;
  localparam int VAL_W       = lrukv_pkg::VAL_W;
  localparam int CAP_W       = lrukv_pkg::CAP_W;
  localparam int MAX_ENTRIES = lrukv_pkg::MAX_ENTRIES;
  localparam logic signed [VAL_W-1:0] MISS_VALUE = -1;
  localparam logic signed [VAL_W-1:0] SET_VALUE  = 0;

  typedef struct packed {
    logic                    hit;
    logic signed [VAL_W-1:0] read_value;
  } response_t;

  response_t            response_q[$];
  logic [KEY_W-1:0]     slot_key   [MAX_ENTRIES];
  logic [VAL_W-1:0]     slot_value [MAX_ENTRIES];
  logic                 slot_valid [MAX_ENTRIES];
  int                   slot_age   [MAX_ENTRIES];
  int                   fill_count;
  logic [CAP_W-1:0]     capacity;
  int                   errors;
  response_t            expected;

  function automatic int entry_limit();
    if (capacity == '0) begin
      return 1;
    end
    if (int'(capacity) > MAX_ENTRIES) begin
      return MAX_ENTRIES;
    end
    return int'(capacity);
  endfunction

  function automatic void make_newest(input int s);
    int r;
    r = slot_age[s];
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      if (slot_valid[i] && i != s && slot_age[i] < r) begin
        slot_age[i]++;
      end
    end
    slot_age[s] = 0;
  endfunction

  function automatic response_t cache_access(input logic cmd,
                                             input logic [KEY_W-1:0] key,
                                             input logic [VAL_W-1:0] val);
    response_t resp;
    int        slot;
    bit        found;
    int        worst;
    slot  = 0;
    found = 0;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      if (!found && slot_valid[i] && slot_key[i] == key) begin
        slot  = i;
        found = 1;
      end
    end
    resp.hit        = found;
    resp.read_value = SET_VALUE;
    if (cmd == lrukv_pkg::CMD_GET) begin
      if (found) begin
        resp.read_value = slot_value[slot];
        make_newest(slot);
      end else begin
        resp.read_value = MISS_VALUE;
      end
      return resp;
    end
    if (found) begin
      slot_value[slot] = val;
      make_newest(slot);
      return resp;
    end
    if (fill_count < entry_limit()) begin
      found = 0;
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        if (!found && !slot_valid[i]) begin
          slot  = i;
          found = 1;
        end
      end
      fill_count++;
      slot_age[slot] = MAX_ENTRIES;
    end else begin
      worst = -1;
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        if (slot_valid[i] && slot_age[i] > worst) begin
          worst = slot_age[i];
          slot  = i;
        end
      end
    end
    slot_valid[slot] = 1'b1;
    slot_key[slot]   = key;
    slot_value[slot] = val;
    make_newest(slot);
    return resp;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        slot_valid[i] = 1'b0;
        slot_age[i]   = 0;
        slot_key[i]   = '0;
        slot_value[i] = '0;
      end
      fill_count = 0;
      capacity   = lrukv_pkg::CAP_RESET;
      response_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        capacity = cfg_data;
      end
      if (start && !busy) begin
        response_q.push_back(cache_access(in_command, in_key, in_value));
      end
      if (out_valid) begin
        if (response_q.size() == 0) begin
          if (errors < 10) begin
            $display("%0t: unexpected result hit=%0b read_value=%0d",
                     $time, out_hit, out_read_value);
          end
          errors++;
        end else begin
          expected = response_q.pop_front();
          if (expected.hit !== out_hit || expected.read_value !== out_read_value) begin
            if (errors < 10) begin
              $display({"%0t: result mismatch: expected hit=%0b read_value=%0d,",
                        " got hit=%0b read_value=%0d"},
                       $time, expected.hit, expected.read_value, out_hit,
                       out_read_value);
            end
            errors++;
          end
        end
      end
    end
    error_count   <= errors;
    pending_count <= response_q.size();
  end

endmodule

FILE: sim/lru_key_value_cache_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRU key/value cache testbench
// Drives directed and random get/set transactions under a series of capacity
// settings with random gaps, and gives the verdict from the checker's counts.
// ----------------------------------------------------------------------------
module lru_key_value_cache_tb;

  localparam int KEY_W            = lrukv_pkg::KEY_W;
  localparam int VAL_W            = lrukv_pkg::VAL_W;
  localparam int CAP_W            = lrukv_pkg::CAP_W;
  localparam int MAX_ENTRIES      = lrukv_pkg::MAX_ENTRIES;
  localparam int IDLE_LIMIT       = 2000;
  localparam int ITEMS_PER_PHASE  = 75;
  localparam int POOL_SIZE        = 32;

  logic                    clk;
  logic                    rst_n      = 1'b0;
  logic                    start      = 1'b0;
  logic                    in_command = lrukv_pkg::CMD_GET;
  logic [KEY_W-1:0]        in_key     = '0;
  logic signed [VAL_W-1:0] in_value   = '0;
  logic                    cfg_valid  = 1'b0;
  logic [CAP_W-1:0]        cfg_data   = '0;
  wire                     busy;
  wire                     out_valid;
  wire                     out_hit;
  wire signed [VAL_W-1:0]  out_read_value;
  wire                     cfg_ready;
  int                      error_count;
  int                      pending_count;
  int                      idle_cycles = 0;
  logic [KEY_W-1:0]        key_pool [POOL_SIZE];
  bit                      steady = 0;

  lru_key_value_cache dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_command     (in_command),
    .in_key         (in_key),
    .in_value       (in_value),
    .out_valid      (out_valid),
    .out_hit        (out_hit),
    .out_read_value (out_read_value),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data)
  );

  lru_key_value_cache_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_command     (in_command),
    .in_key         (in_key),
    .in_value       (in_value),
    .out_valid      (out_valid),
    .out_hit        (out_hit),
    .out_read_value (out_read_value),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data),
    .error_count    (error_count),
    .pending_count  (pending_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if ((start && !busy) || out_valid || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 50) begin
      return 0;
    end
    if (r < 85) begin
      return $urandom_range(1, 3);
    end
    if (r < 97) begin
      return $urandom_range(4, 10);
    end
    return $urandom_range(20, 40);
  endfunction

  task automatic issue(input logic cmd, input logic [KEY_W-1:0] key,
                       input logic [VAL_W-1:0] val);
    int gap;
    start      <= 1'b1;
    in_command <= cmd;
    in_key     <= key;
    in_value   <= val;
    do @(posedge clk); while (busy);
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [CAP_W-1:0] cap);
    cfg_valid <= 1'b1;
    cfg_data  <= cap;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_phase(input logic [CAP_W-1:0] cap, input int items);
    int               limit;
    int               span;
    logic             cmd;
    logic [KEY_W-1:0] key;
    wait_idle();
    write_capacity(cap);
    limit = (cap == '0) ? 1 : ((int'(cap) > MAX_ENTRIES) ? MAX_ENTRIES : int'(cap));
    span  = (limit + 3 < POOL_SIZE) ? limit + 3 : POOL_SIZE - 1;
    steady = ($urandom_range(0, 3) == 0);
    for (int i = 2; i < POOL_SIZE; i++) begin
      if ($urandom_range(0, 3) == 0) begin
        key_pool[i] = KEY_W'($urandom);
      end
    end
    repeat (items) begin
      if ($urandom_range(0, 19) == 0) begin
        key = KEY_W'($urandom);
      end else begin
        key = key_pool[$urandom_range(0, span)];
      end
      cmd = ($urandom_range(0, 99) < 55) ? lrukv_pkg::CMD_SET : lrukv_pkg::CMD_GET;
      issue(cmd, key, $urandom);
    end
  endtask

  initial begin
    key_pool[0] = '0;
    key_pool[1] = '1;
    for (int i = 2; i < POOL_SIZE; i++) begin
      key_pool[i] = KEY_W'($urandom);
    end
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    wait_idle();
    write_capacity(lrukv_pkg::CAP_RESET);

    issue(lrukv_pkg::CMD_GET, 16'h0000, 32'h0000_0000);
    issue(lrukv_pkg::CMD_SET, 16'h0000, 32'h7FFF_FFFF);
    issue(lrukv_pkg::CMD_SET, 16'hFFFF, 32'h8000_0000);
    issue(lrukv_pkg::CMD_GET, 16'h0000, 32'hFFFF_FFFF);
    issue(lrukv_pkg::CMD_GET, 16'hFFFF, 32'h0000_0000);
    issue(lrukv_pkg::CMD_SET, 16'h0000, 32'hFFFF_FFFF);
    issue(lrukv_pkg::CMD_GET, 16'h0000, 32'h1234_5678);
    issue(lrukv_pkg::CMD_GET, 16'h1234, 32'h0000_0000);
    for (int k = 1; k <= 14; k++) begin
      issue(lrukv_pkg::CMD_SET, KEY_W'(k), 32'h5A5A_0000 | VAL_W'(k));
    end
    issue(lrukv_pkg::CMD_GET, 16'hFFFF, 32'h0000_0000);
    issue(lrukv_pkg::CMD_SET, 16'h8000, 32'h0000_0005);
    issue(lrukv_pkg::CMD_GET, 16'h0000, 32'h0000_0000);

    run_phase(5'd1, ITEMS_PER_PHASE);
    run_phase(5'd0, ITEMS_PER_PHASE);
    run_phase(5'd31, ITEMS_PER_PHASE);
    run_phase(5'd2, ITEMS_PER_PHASE);
    run_phase(5'd17, ITEMS_PER_PHASE);
    run_phase(5'd4, ITEMS_PER_PHASE);
    run_phase(5'd16, ITEMS_PER_PHASE);
    repeat (3) run_phase(CAP_W'($urandom_range(0, 31)), ITEMS_PER_PHASE);

    wait_idle();
    if (error_count == 0 && pending_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/core/lrukv_pkg.sv
rtl/core/lrukv_ctrl.sv
rtl/core/lrukv_dp.sv
rtl/core/lru_key_value_cache.sv
rtl/core/lrukv_checker.sv
sim/lru_key_value_cache_checker.sv
sim/lru_key_value_cache_tb.sv
